[hdl/mi3_pkg.sv]
// Shared constants for the 3x3 matrix inverse / adjugate block.
`default_nettype none
package mi3_pkg;
  // operation selector codes
  localparam logic FUNC_INV = 1'b0;
  localparam logic FUNC_ADJ = 1'b1;
endpackage
`default_nettype wire

[hdl/matrix3_inverse_adjoint_top.sv]
// Top level: 3x3 inverse / adjugate with nine divider lanes and an output register.
// Throughput: one matrix per cycle while the output is not stalled;
// every stage is pipelined, nine lanes in parallel.
// Whole pipeline advances together; it holds while the output register is stalled.
// Reset (rst, synchronous) clears all valid flags; data registers are not reset.
`default_nettype none
module matrix3_inverse_adjoint_top #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic      s_tready,
  // a00,a01,a02,a10,a11,a12,a20,a21,a22 from bit 0 up
  input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  // func
  input  wire logic s_tuser,
  output logic      m_tvalid,
  input  wire logic m_tready,
  // r00,r01,r02,r10,r11,r12,r20,r21,r22,det_value from bit 0 up
  output logic [((10*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  // singular
  output logic      m_tuser
);
  localparam int DW  = DATA_WIDTH;
  localparam int DTW = 3*DW+3;
  localparam int OBW = ((10*DW+7)/8)*8;
  localparam int LAT = DW + 6;

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  logic signed [DW-1:0]   m [9];
  logic signed [2*DW:0]   c [9];
  logic signed [DTW-1:0]  det;
  logic                   func_d;
  logic signed [DW-1:0]   r [9];

  genvar gi;
  generate
    for (gi = 0; gi < 9; gi++) begin : g_in
      assign m[gi] = $signed(s_tdata[gi*DW +: DW]);
    end
  endgenerate

  mi3_det #(.DW(DW)) u_det (
    .clk(clk), .en(adv), .m(m), .func_in(s_tuser),
    .func(func_d), .c(c), .det(det)
  );

  generate
    for (gi = 0; gi < 9; gi++) begin : g_lane
      mi3_lane #(.DW(DW), .F(FRAC_BITS)) u_lane (
        .clk(clk), .en(adv), .c(c[gi]), .det(det), .func(func_d), .r(r[gi])
      );
    end
  endgenerate

  // determinant rescale and saturation
  logic signed [DTW-1:0] dsh;
  logic [DW-1:0]         dv_c;
  always_comb begin
    dsh = det >>> (2*FRAC_BITS);
    if (dsh[DTW-1:DW-1] == '0 || dsh[DTW-1:DW-1] == '1)
      dv_c = dsh[DW-1:0];
    else if (dsh[DTW-1])
      dv_c = {1'b1, {(DW-1){1'b0}}};
    else
      dv_c = {1'b0, {(DW-1){1'b1}}};
  end

  // determinant delay to line up with the lanes
  logic [DW-1:0] dv [DW+2];
  logic          sn [DW+2];
  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= dv_c;
      sn[0] <= (det == '0);
      for (int j = 1; j < DW+2; j++) begin
        dv[j] <= dv[j-1];
        sn[j] <= sn[j-1];
      end
    end
  end

  // valid chain
  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[LAT-2:0], s_tvalid};
      m_tvalid <= vld[LAT-1];
    end
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      m_tdata <= OBW'({dv[DW+1], r[8], r[7], r[6], r[5], r[4], r[3], r[2], r[1], r[0]});
      m_tuser <= sn[DW+1];
    end
  end
endmodule
`default_nettype wire

[hdl/mi3_det.sv]
// Cofactor and determinant pipeline: exact, full-width, four register stages.
`default_nettype none
module mi3_det #(
  parameter int DW = 32
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic signed [DW-1:0]    m [9],
  input  wire logic                    func_in,
  output logic                         func,
  output logic signed [2*DW:0]         c [9],
  output logic signed [3*DW+2:0]       det
);
  localparam int CW  = 2*DW+1;
  localparam int DTW = 3*DW+3;
  localparam int PW  = 2*DW;

  // cofactor Ci = m[P]*m[Q] - m[R]*m[S]
  localparam int P [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int Q [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int R [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int S [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic signed [PW-1:0]   pa [9];
  logic signed [PW-1:0]   pb [9];
  logic signed [DW-1:0]   mh1 [3];
  logic signed [DW-1:0]   mh2 [3];
  logic signed [CW-1:0]   c2 [9];
  logic signed [CW-1:0]   c3 [9];
  logic signed [CW-1:0]   lo_p [3];
  logic signed [CW-1:0]   hi_p [3];
  logic signed [DTW-1:0]  term [3];
  logic                   f1, f2, f3;

  genvar gi;
  generate
    for (gi = 0; gi < 9; gi++) begin : g_cof
      // stage 1: products, stage 2: difference, stage 3: carry
      always_ff @(posedge clk) begin
        if (en) begin
          pa[gi] <= m[P[gi]] * m[Q[gi]];
          pb[gi] <= m[R[gi]] * m[S[gi]];
          c2[gi] <= CW'(pa[gi]) - CW'(pb[gi]);
          c3[gi] <= c2[gi];
          c[gi]  <= c3[gi];
        end
      end
    end
    for (gi = 0; gi < 3; gi++) begin : g_dp
      // stage 3: first-row element times cofactor, split into two halves
      always_ff @(posedge clk) begin
        if (en) begin
          mh1[gi]  <= m[gi];
          mh2[gi]  <= mh1[gi];
          lo_p[gi] <= mh2[gi] * $signed({1'b0, c2[3*gi][DW-1:0]});
          hi_p[gi] <= mh2[gi] * $signed(c2[3*gi][CW-1:DW]);
        end
      end
      assign term[gi] = (DTW'(hi_p[gi]) <<< DW) + DTW'(lo_p[gi]);
    end
  endgenerate

  // stage 4: determinant sum
  always_ff @(posedge clk) begin
    if (en) begin
      det  <= term[0] + term[1] + term[2];
      f1   <= func_in;
      f2   <= f1;
      f3   <= f2;
      func <= f3;
    end
  end
endmodule
`default_nettype wire

[hdl/mi3_lane.sv]
// One result lane: pipelined restoring divider for the inverse, plus adjugate scaling.
`default_nettype none
module mi3_lane #(
  parameter int DW = 32,
  parameter int F  = 16
) (
  input  wire logic                  clk,
  input  wire logic                  en,
  input  wire logic signed [2*DW:0]  c,
  input  wire logic signed [3*DW+2:0] det,
  input  wire logic                  func,
  output logic signed [DW-1:0]       r
);
  import mi3_pkg::*;

  localparam int CW  = 2*DW+1;
  localparam int DTW = 3*DW+3;
  localparam int NW  = CW + 2*F;
  localparam int WW  = NW + DTW;

  logic              nneg, dneg, ovf_c, sing_c;
  logic [CW-1:0]     cmag;
  logic [NW-1:0]     nmag;
  logic [DTW-1:0]    dmag_c;
  logic [WW-1:0]     nsh;
  logic signed [CW-1:0] csh;
  logic [DW-1:0]     adj_c;

  // magnitudes, overflow test and adjugate scaling
  always_comb begin
    nneg   = c[CW-1];
    dneg   = det[DTW-1];
    cmag   = nneg ? CW'(-c) : CW'(c);
    nmag   = {cmag, {(2*F){1'b0}}};
    dmag_c = dneg ? DTW'(-det) : DTW'(det);
    ovf_c  = WW'(nmag) >= (WW'(dmag_c) << DW);
    nsh    = WW'(nmag) >> DW;
    sing_c = (det == '0);
    csh    = c >>> F;
    if (csh[CW-1:DW-1] == '0 || csh[CW-1:DW-1] == '1)
      adj_c = csh[DW-1:0];
    else if (csh[CW-1])
      adj_c = {1'b1, {(DW-1){1'b0}}};
    else
      adj_c = {1'b0, {(DW-1){1'b1}}};
  end

  logic [DTW-1:0] rem [DW+1];
  logic [DTW-1:0] dm  [DW+1];
  logic [DW-1:0]  nl  [DW+1];
  logic [DW-1:0]  q   [DW+1];
  logic [DW-1:0]  adj [DW+1];
  logic           sgn [DW+1];
  logic           ovf [DW+1];
  logic           fn  [DW+1];
  logic           sg  [DW+1];

  // prep register
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= nsh[DTW-1:0];
      dm[0]  <= dmag_c;
      nl[0]  <= nmag[DW-1:0];
      q[0]   <= '0;
      adj[0] <= adj_c;
      sgn[0] <= nneg ^ dneg;
      ovf[0] <= ovf_c;
      fn[0]  <= func;
      sg[0]  <= sing_c;
    end
  end

  // one quotient bit per stage
  genvar gk;
  generate
    for (gk = 0; gk < DW; gk++) begin : g_stage
      logic [DTW:0] trial, diff;
      logic         ge;
      always_comb begin
        trial = {rem[gk], nl[gk][DW-1]};
        diff  = trial - {1'b0, dm[gk]};
        ge    = !diff[DTW];
      end
      always_ff @(posedge clk) begin
        if (en) begin
          rem[gk+1] <= ge ? diff[DTW-1:0] : trial[DTW-1:0];
          dm[gk+1]  <= dm[gk];
          nl[gk+1]  <= nl[gk] << 1;
          q[gk+1]   <= {q[gk][DW-2:0], ge};
          adj[gk+1] <= adj[gk];
          sgn[gk+1] <= sgn[gk];
          ovf[gk+1] <= ovf[gk];
          fn[gk+1]  <= fn[gk];
          sg[gk+1]  <= sg[gk];
        end
      end
    end
  endgenerate

  // sign, saturation and result select
  logic [DW-1:0] qv;
  always_comb begin
    if (!sgn[DW]) begin
      if (ovf[DW] || q[DW][DW-1]) qv = {1'b0, {(DW-1){1'b1}}};
      else                        qv = q[DW];
    end else begin
      if (ovf[DW] || q[DW] > {1'b1, {(DW-1){1'b0}}}) qv = {1'b1, {(DW-1){1'b0}}};
      else                                           qv = DW'(-q[DW]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fn[DW] == FUNC_ADJ) r <= $signed(adj[DW]);
      else if (sg[DW])        r <= '0;
      else                    r <= $signed(qv);
    end
  end
endmodule
`default_nettype wire

[bench/testbench.sv]
// Self-checking bench for the 3x3 matrix inverse / adjugate block.
`timescale 1ns / 1ps
module testbench;
  import mi3_pkg::*;

  localparam int DW  = 32;
  localparam int FB  = 16;
  localparam int WW  = 256;
  localparam int LAT = DW + 7;

  typedef logic signed [WW-1:0] wide_t;

  typedef struct packed {
    logic              singular;
    logic [10*DW-1:0]  data;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [9*DW-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [10*DW-1:0] m_tdata;
  logic m_tuser;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int n_errors = 0;
  result_t expected_results[$];

  always #2 clk = ~clk;

  matrix3_inverse_adjoint_top #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // saturate a wide signed value to DW bits
  function automatic logic [DW-1:0] sat_dw(input wide_t v);
    wide_t hi;
    hi = v >>> (DW - 1);
    if (hi == 0 || hi == -1) return v[DW-1:0];
    return v[WW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  // inverse / adjugate prediction for one matrix
  function automatic result_t predict_inverse(input logic fn, input logic [9*DW-1:0] mat);
    wide_t m[9];
    wide_t c[9];
    wide_t det;
    result_t r;
    for (int i = 0; i < 9; i++) m[i] = wide_t'($signed(mat[i*DW +: DW]));
    c[0] = m[4]*m[8] - m[5]*m[7];
    c[1] = m[2]*m[7] - m[1]*m[8];
    c[2] = m[1]*m[5] - m[2]*m[4];
    c[3] = m[5]*m[6] - m[3]*m[8];
    c[4] = m[0]*m[8] - m[2]*m[6];
    c[5] = m[2]*m[3] - m[0]*m[5];
    c[6] = m[3]*m[7] - m[4]*m[6];
    c[7] = m[1]*m[6] - m[0]*m[7];
    c[8] = m[0]*m[4] - m[1]*m[3];
    det = m[0]*c[0] + m[1]*c[3] + m[2]*c[6];
    r.singular = (det == 0);
    for (int i = 0; i < 9; i++) begin
      if (fn == FUNC_ADJ) r.data[i*DW +: DW] = sat_dw(c[i] >>> FB);
      else if (r.singular) r.data[i*DW +: DW] = '0;
      else r.data[i*DW +: DW] = sat_dw((c[i] <<< (2*FB)) / det);
    end
    r.data[9*DW +: DW] = sat_dw(det >>> (2*FB));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    n_errors++;
  endtask

  // send one matrix, random idle cycles before it; tvalid stays up after the transfer
  task automatic send_matrix(input logic fn, input logic [9*DW-1:0] mat);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= fn;
    s_tdata  <= mat;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_results.push_back(predict_inverse(fn, mat));
  endtask

  // output back-pressure
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // check each result transfer
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_tdata[DW-1:0], '0);
      end else begin
        result_t e;
        e = expected_results.pop_front();
        for (int i = 0; i < 10; i++)
          if (m_tdata[i*DW +: DW] !== e.data[i*DW +: DW])
            report_mismatch($sformatf("field %0d", i), m_tdata[i*DW +: DW],
                            e.data[i*DW +: DW]);
        if (m_tuser !== e.singular)
          report_mismatch("singular", DW'(m_tuser), DW'(e.singular));
      end
    end
  end

  function automatic logic [DW-1:0] rand_elem();
    case ($urandom_range(5))
      0: return $urandom;
      1: return DW'($signed($urandom_range(8, 0)) - 4) << FB;   // small integers
      2: return {{(DW-20){1'($urandom_range(1))}}, 20'($urandom)};   // modest values
      3: return $urandom_range(1) ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
      default: return DW'($signed($urandom_range(512)) - 256) << ($urandom_range(FB));
    endcase
  endfunction

  function automatic logic [9*DW-1:0] rand_matrix();
    logic [9*DW-1:0] mt;
    for (int i = 0; i < 9; i++) mt[i*DW +: DW] = rand_elem();
    // now and then make row 2 a copy of row 0 for a singular case
    if ($urandom_range(9) == 0) mt[6*DW +: 3*DW] = mt[0 +: 3*DW];
    return mt;
  endfunction

  task automatic test_directed();
    logic [DW-1:0] one, mx, mn;
    logic [9*DW-1:0] ident;
    logic [3*DW-1:0] gap;
    one = DW'(1) << FB;
    mx = {1'b0, {(DW-1){1'b1}}};
    mn = {1'b1, {(DW-1){1'b0}}};
    gap = '0;
    ident = {one, gap, one, gap, one};
    send_matrix(FUNC_INV, ident);
    send_matrix(FUNC_ADJ, ident);
    send_matrix(FUNC_INV, '0);                       // singular, zero matrix
    send_matrix(FUNC_ADJ, '0);
    send_matrix(FUNC_INV, {9{mx}});                  // singular, all equal
    send_matrix(FUNC_ADJ, {9{mn}});
    send_matrix(FUNC_INV, {mx, gap, mn, gap, mx});   // huge determinant
    send_matrix(FUNC_ADJ, {mn, gap, mx, gap, mn});
    send_matrix(FUNC_INV, {DW'(1), gap, DW'(1), gap, DW'(1)});  // tiny determinant
    send_matrix(FUNC_INV, {DW'(3), gap, DW'(1), gap, DW'(-2)});
    send_matrix(FUNC_INV, {9*DW{1'b1}});
    send_matrix(FUNC_ADJ, {9*DW{1'b1}});
    send_matrix(FUNC_INV, {mn, mx, mn, mx, mn, mx, mx, mn, mx});
    send_matrix(FUNC_ADJ, {mn, mx, mn, mx, mn, mx, mx, mn, mx});
    send_matrix(FUNC_INV, {one, one, 32'h0, 32'h0, one, one, one, 32'h0, one});
  endtask

  task automatic test_random(input int n, input int idle, input int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) send_matrix(logic'($urandom_range(1)), rand_matrix());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(400, 0, 0);
    test_random(400, 80, 0);
    test_random(400, 0, 80);
    test_random(400, 22, 22);
    s_tvalid <= 1'b0;
    recv_stall_pct = 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    if (n_errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Mismatches found");
    $finish;
  end
endmodule

[filelist.f]
hdl/mi3_pkg.sv
hdl/mi3_det.sv
hdl/mi3_lane.sv
hdl/matrix3_inverse_adjoint_top.sv
bench/testbench.sv
